// File: rtl/core/csmv_pkg.sv
// csmv_pkg: shared types and constants of the csr sparse matvec accumulate block
// used by csmv_front, csmv_fifo, csmv_back and csr_sparse_matvec_accumulate
// no dependencies
package csmv_pkg;

  localparam int unsigned IndexW   = 12;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned RowW     = 16;
  localparam int unsigned AccW     = 48;
  localparam int unsigned ProdW    = 2 * ValueW;
  localparam int unsigned FracBits = 16;

  // command queue between front and back
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueLevelW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    FUNC_LOAD_X    = 2'd0,
    FUNC_ROW_BEGIN = 2'd1,
    FUNC_NONZERO   = 2'd2,
    FUNC_ROW_END   = 2'd3
  } func_e;

  // one classified request, with the x operand already fetched
  typedef struct packed {
    func_e                    func;
    logic signed [ValueW-1:0] value;
    logic signed [ValueW-1:0] xval;
  } cmd_t;

endpackage

// File: rtl/core/csr_sparse_matvec_accumulate.sv
// csr_sparse_matvec_accumulate: fixed-point y += A*x over CSR request streams
// depends on csmv_pkg, csmv_front, csmv_fifo, csmv_back
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   func_i, index_i, value_i
//   out      out_valid_o / out_ready_i row_number_o, row_sum_o, saturated_o
//
// one request per cycle unless the queue fills or a row end waits on a full output;
// a row end crosses fetch, queue and multiply registers to the output register
// the accumulator add closes each cycle so nonzeros run back to back
// rst_ni clears counters, accumulator and queue at once; x store is not cleared
// a full output register holds only row ends, the queue absorbs the slip
module csr_sparse_matvec_accumulate #(
  parameter int unsigned X_DEPTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic [csmv_pkg::IndexW-1:0] index_i,
  input  logic [csmv_pkg::ValueW-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [csmv_pkg::RowW-1:0]   row_number_o,
  output logic [csmv_pkg::ValueW-1:0] row_sum_o,
  output logic                        saturated_o
);
  import csmv_pkg::*;

  logic                   push;
  cmd_t                   push_cmd;
  logic                   pop_valid;
  logic                   pop;
  cmd_t                   pop_cmd;
  logic [QueueLevelW-1:0] level;

  // front: request intake and x store
  csmv_front #(
    .XDepth(X_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_e'(func_i)),
    .index_i    (index_i),
    .value_i    (value_i),
    .level_i    (level),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // decoupling queue
  csmv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_cmd_o   (pop_cmd),
    .level_o     (level)
  );

  // back: multiply-accumulate and row output
  csmv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_cmd_i    (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_number_o (row_number_o),
    .row_sum_o    (row_sum_o),
    .saturated_o  (saturated_o)
  );

endmodule

// File: rtl/core/csmv_front.sv
// csmv_front: accepts requests, owns the x vector store, fetches x for nonzeros
// depends on csmv_pkg; feeds csmv_fifo
module csmv_front #(
  parameter int unsigned XDepth = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  csmv_pkg::func_e              func_i,
  input  logic [csmv_pkg::IndexW-1:0]  index_i,
  input  logic [csmv_pkg::ValueW-1:0]  value_i,
  input  logic [csmv_pkg::QueueLevelW-1:0] level_i,
  output logic                         push_o,
  output csmv_pkg::cmd_t               push_cmd_o
);
  import csmv_pkg::*;

  localparam int unsigned AddrW = (XDepth > 1) ? $clog2(XDepth) : 1;
  localparam int unsigned CmpW  = 17;
  localparam logic [QueueLevelW:0] QueueFull = (QueueLevelW + 1)'(QueueDepth);

  logic [ValueW-1:0] xmem [XDepth];

  logic              accept;
  logic [CmpW-1:0]   idx_ext;
  logic              in_range;
  logic [AddrW-1:0]  addr;

  logic              s1_valid_q, s1_valid_d;
  func_e             s1_func_q;
  logic [ValueW-1:0] s1_value_q;
  logic              s1_inr_q;
  logic [ValueW-1:0] rdata_q;

  // room check counts the request already in the fetch stage
  assign in_ready_o = ((QueueLevelW + 1)'(level_i) + (QueueLevelW + 1)'(s1_valid_q)) < QueueFull;
  assign accept     = in_valid_i & in_ready_o;

  // address decode and range check
  assign idx_ext  = CmpW'(index_i);
  assign in_range = idx_ext < CmpW'(XDepth);
  assign addr     = AddrW'(idx_ext);

  // x store: write on load, registered read for every other request
  always_ff @(posedge clk_i) begin
    if (accept && (func_i == FUNC_LOAD_X) && in_range) begin
      xmem[addr] <= value_i;
    end
    if (accept) begin
      rdata_q <= xmem[addr];
    end
  end

  // fetch stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q  <= func_i;
      s1_value_q <= value_i;
      s1_inr_q   <= in_range;
    end
  end

  // loads end here, the rest move on to the queue
  assign s1_valid_d = accept && (func_i != FUNC_LOAD_X);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // queue push, x forced to zero beyond the store
  assign push_o           = s1_valid_q;
  assign push_cmd_o.func  = s1_func_q;
  assign push_cmd_o.value = s1_value_q;
  assign push_cmd_o.xval  = s1_inr_q ? rdata_q : '0;

endmodule

// File: rtl/core/csmv_fifo.sv
// csmv_fifo: short command queue between csmv_front and csmv_back
// depends on csmv_pkg
module csmv_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  csmv_pkg::cmd_t                   push_cmd_i,
  output logic                             pop_valid_o,
  input  logic                             pop_i,
  output csmv_pkg::cmd_t                   pop_cmd_o,
  output logic [csmv_pkg::QueueLevelW-1:0] level_o
);
  import csmv_pkg::*;

  localparam logic [QueuePtrW-1:0]   PtrLast = QueuePtrW'(QueueDepth - 1);
  localparam logic [QueueLevelW-1:0] LevelMax = QueueLevelW'(QueueDepth);

  cmd_t                   entries_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueLevelW-1:0] level_q, level_d;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointer and level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  assign pop_valid_o = (level_q != '0);
  assign pop_cmd_o   = entries_q[rd_ptr_q];
  assign level_o     = level_q;

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> level_q < LevelMax)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> level_q != '0)
    else $error("command queue underflow");

endmodule

// File: rtl/core/csmv_back.sv
// csmv_back: multiply stage, 48-bit accumulator, row-end saturation, output register
// depends on csmv_pkg; drained from csmv_fifo
module csmv_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  input  csmv_pkg::cmd_t              pop_cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [csmv_pkg::RowW-1:0]   row_number_o,
  output logic [csmv_pkg::ValueW-1:0] row_sum_o,
  output logic                        saturated_o
);
  import csmv_pkg::*;

  localparam logic [ValueW-1:0] SumMax = {1'b0, {(ValueW - 1){1'b1}}};
  localparam logic [ValueW-1:0] SumMin = {1'b1, {(ValueW - 1){1'b0}}};

  logic                     a_valid_q, a_valid_d;
  func_e                    a_func_q;
  logic [ValueW-1:0]        a_value_q;
  logic signed [ProdW-1:0]  a_prod_q;
  logic signed [ProdW-1:0]  prod;

  logic [AccW-1:0]          acc_q, acc_d;
  logic [RowW-1:0]          row_q, row_d;
  logic                     stall, adv, row_done;

  logic [AccW-ValueW:0]     acc_hi;
  logic                     sat;
  logic [ValueW-1:0]        clamped;

  logic                     out_valid_q, out_valid_d;
  logic [RowW-1:0]          out_row_q;
  logic [ValueW-1:0]        out_sum_q;
  logic                     out_sat_q;

  // a row end waits only while the output register is still full
  assign stall = a_valid_q && (a_func_q == FUNC_ROW_END) && out_valid_q && !out_ready_i;
  assign adv   = !stall;
  assign pop_o = pop_valid_i && adv;

  // multiply stage
  assign prod = pop_cmd_i.value * pop_cmd_i.xval;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_func_q  <= pop_cmd_i.func;
      a_value_q <= pop_cmd_i.value;
      a_prod_q  <= prod;
    end
  end

  assign a_valid_d = adv ? pop_valid_i : a_valid_q;

  // accumulate stage
  always_comb begin
    acc_d    = acc_q;
    row_d    = row_q;
    row_done = 1'b0;
    if (a_valid_q && adv) begin
      unique case (a_func_q)
        FUNC_ROW_BEGIN: acc_d = {{(AccW - ValueW){a_value_q[ValueW-1]}}, a_value_q};
        FUNC_NONZERO:   acc_d = acc_q + a_prod_q[ProdW-1:FracBits];
        FUNC_ROW_END: begin
          acc_d    = '0;
          row_d    = row_q + 1'b1;
          row_done = 1'b1;
        end
        default:        acc_d = acc_q;
      endcase
    end
  end

  // clip to the 32-bit range when the upper bits are not a sign extension
  assign acc_hi  = acc_q[AccW-1:ValueW-1];
  assign sat     = !((&acc_hi) || !(|acc_hi));
  assign clamped = sat ? (acc_q[AccW-1] ? SumMin : SumMax) : acc_q[ValueW-1:0];

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (row_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_done) begin
      out_row_q <= row_q;
      out_sum_q <= clamped;
      out_sat_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      acc_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      acc_q       <= acc_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_number_o = out_row_q;
  assign row_sum_o    = out_sum_q;
  assign saturated_o  = out_sat_q;

  // a finished row shows up with the accumulator cleared and the row count advanced
  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_done |=> out_valid_q && (acc_q == '0) && (row_q == $past(row_q) + 1'b1))
    else $error("row end did not retire correctly");

  // a stalled row end leaves the running sum untouched
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(acc_q) && a_valid_q)
    else $error("accumulator changed during output stall");

endmodule

// File: tb/sv/csmv_row_checker.sv
// csmv_row_checker: watches both channels of csr_sparse_matvec_accumulate,
// predicts each row sum from the accepted requests and compares field by field
// depends on csmv_pkg only
module csmv_row_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    func_i,
  input  logic [csmv_pkg::IndexW-1:0]   index_i,
  input  logic [csmv_pkg::ValueW-1:0]   value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [csmv_pkg::RowW-1:0]     row_number_i,
  input  logic [csmv_pkg::ValueW-1:0]   row_sum_i,
  input  logic                          saturated_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   rows_pending_o,
  output int unsigned                   rows_checked_o,
  output int unsigned                   rows_clipped_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import csmv_pkg::*;

  localparam int unsigned XEntries = 1 << IndexW;
  localparam int unsigned ReportMax = 10;

  // q32.16 bounds of a q16.16 row sum
  localparam logic signed [AccW-1:0] SumMax =
    {{(AccW-ValueW+1){1'b0}}, {(ValueW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SumMin =
    {{(AccW-ValueW+1){1'b1}}, {(ValueW-1){1'b0}}};

  typedef struct packed {
    logic [RowW-1:0]   row_number;
    logic [ValueW-1:0] row_sum;
    logic              saturated;
  } row_sum_t;

  row_sum_t          expected_sums[$];
  logic [ValueW-1:0] x_vector[XEntries];
  logic [AccW-1:0]   acc_sum;
  logic [RowW-1:0]   row_index;
  int unsigned       fails;
  int unsigned       checked;
  int unsigned       clipped;

  // predict on every accepted request, compare on every accepted row sum
  always @(posedge clk_i or negedge rst_ni) begin
    row_sum_t                 want;
    row_sum_t                 got;
    logic signed [ProdW-1:0]  product;
    logic signed [AccW-1:0]   total;
    if (!rst_ni) begin
      expected_sums.delete();
      acc_sum   = '0;
      row_index = '0;
      fails     = 0;
      checked   = 0;
      clipped   = 0;
    end else begin
      // request side
      if (in_valid_i && in_ready_i) begin
        case (func_e'(func_i))
          FUNC_LOAD_X: x_vector[index_i] = value_i;
          FUNC_ROW_BEGIN: acc_sum = {{(AccW-ValueW){value_i[ValueW-1]}}, value_i};
          FUNC_NONZERO: begin
            // q32.32 product, floor shift to q32.16, wraps in the accumulator
            product = $signed(value_i) * $signed(x_vector[index_i]);
            acc_sum = acc_sum + product[ProdW-1:FracBits];
          end
          default: begin
            total = $signed(acc_sum);
            want.row_number = row_index;
            want.saturated  = 1'b1;
            if (total > SumMax) begin
              want.row_sum = SumMax[ValueW-1:0];
            end else if (total < SumMin) begin
              want.row_sum = SumMin[ValueW-1:0];
            end else begin
              want.row_sum   = total[ValueW-1:0];
              want.saturated = 1'b0;
            end
            if (want.saturated) clipped++;
            expected_sums.push_back(want);
            row_index = row_index + 1'b1;
            acc_sum   = '0;
          end
        endcase
      end
      // result side
      if (out_valid_i && out_ready_i) begin
        got.row_number = row_number_i;
        got.row_sum    = row_sum_i;
        got.saturated  = saturated_i;
        if (expected_sums.size() == 0) begin
          fails++;
          if (fails <= ReportMax)
            $display("%0t: row sum with none pending: row %0d sum %h sat %0b",
                     $realtime, got.row_number, got.row_sum, got.saturated);
        end else begin
          want = expected_sums.pop_front();
          checked++;
          if (got.row_number != want.row_number || got.row_sum != want.row_sum ||
              got.saturated != want.saturated) begin
            fails++;
            if (fails <= ReportMax)
              $display("%0t: expected row %0d sum %h sat %0b, got row %0d sum %h sat %0b",
                       $realtime, want.row_number, want.row_sum, want.saturated,
                       got.row_number, got.row_sum, got.saturated);
          end
        end
      end
    end
    fail_count_o   <= fails;
    rows_pending_o <= expected_sums.size();
    rows_checked_o <= checked;
    rows_clipped_o <= clipped;
  end

endmodule

// File: tb/sv/tb_csr_sparse_matvec_accumulate.sv
// tb_csr_sparse_matvec_accumulate: stimulus and verdict for the csr sparse matvec block
// drives directed and random csr request streams under several idle and stall mixes
// depends on csmv_pkg, csr_sparse_matvec_accumulate and csmv_row_checker
module tb_csr_sparse_matvec_accumulate;
  timeunit 1ns;
  timeprecision 1ps;
  import csmv_pkg::*;

  localparam int unsigned PhaseItems    = 440;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned WatchdogLimit = 4000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [1:0]        func_i      = FUNC_LOAD_X;
  logic [IndexW-1:0] index_i     = '0;
  logic [ValueW-1:0] value_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [RowW-1:0]   row_number_o;
  logic [ValueW-1:0] row_sum_o;
  logic              saturated_o;

  int unsigned fail_count;
  int unsigned rows_pending;
  int unsigned rows_checked;
  int unsigned rows_clipped;

  int unsigned       idle_pct  = 0;
  int unsigned       stall_pct = 0;
  int unsigned       requests_sent = 0;
  int unsigned       quiet_cycles = 0;
  bit                x_loaded[1 << IndexW];
  logic [IndexW-1:0] loaded_cols[$];

  csr_sparse_matvec_accumulate dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_number_o (row_number_o),
    .row_sum_o    (row_sum_o),
    .saturated_o  (saturated_o)
  );

  csmv_row_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .func_i         (func_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_number_i   (row_number_o),
    .row_sum_i      (row_sum_o),
    .saturated_i    (saturated_o),
    .fail_count_o   (fail_count),
    .rows_pending_o (rows_pending),
    .rows_checked_o (rows_checked),
    .rows_clipped_o (rows_clipped)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls at the current phase rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // cycles with no request and no row sum accepted
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
    $display("Mismatches found");
    $finish;
  end

  // q16.16 operand: full range, extremes, or a few units around zero
  function automatic logic [ValueW-1:0] rand_value();
    logic [ValueW-1:0] pick;
    case ($urandom_range(0, 9))
      0, 1, 2: pick = $urandom;
      3: begin
        case ($urandom_range(0, 3))
          0:       pick = 32'h7FFF_FFFF;
          1:       pick = 32'h8000_0000;
          2:       pick = '0;
          default: pick = '1;
        endcase
      end
      default: pick = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
    return pick;
  endfunction

  // column that has already been loaded
  function automatic logic [IndexW-1:0] loaded_column();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  // one request, with a random gap before it
  task automatic send_request(input func_e f, input logic [IndexW-1:0] idx,
                              input logic [ValueW-1:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    index_i    <= idx;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
    if (f == FUNC_LOAD_X && !x_loaded[idx]) begin
      x_loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
  endtask

  // well-formed row: begin, nonzeros with occasional loads, end
  task automatic send_row();
    int unsigned nonzeros;
    nonzeros = $urandom_range(0, 8);
    send_request(FUNC_ROW_BEGIN, IndexW'($urandom), rand_value());
    repeat (nonzeros) begin
      if ($urandom_range(0, 4) == 0)
        send_request(FUNC_LOAD_X, IndexW'($urandom), rand_value());
      send_request(FUNC_NONZERO, loaded_column(), rand_value());
    end
    send_request(FUNC_ROW_END, IndexW'($urandom), rand_value());
  endtask

  // stray request outside a well-formed row
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0:       send_request(FUNC_LOAD_X, IndexW'($urandom), rand_value());
      1:       send_request(FUNC_NONZERO, loaded_column(), rand_value());
      2:       send_request(FUNC_ROW_BEGIN, IndexW'($urandom), rand_value());
      default: send_request(FUNC_ROW_END, IndexW'($urandom), rand_value());
    endcase
  endtask

  // hold off the sender until every row sum has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned phase_start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, rows without begin, saturation both ways,
    // accumulator wrap, reopened row and floor rounding
    send_request(FUNC_LOAD_X,    12'h000, 32'h7FFF_FFFF);
    send_request(FUNC_LOAD_X,    12'hFFF, 32'h8000_0000);
    send_request(FUNC_LOAD_X,    12'hAAA, 32'h0001_0000);
    send_request(FUNC_LOAD_X,    12'h555, 32'hFFFF_8000);
    send_request(FUNC_ROW_END,   12'hFFF, 32'hFFFF_FFFF);
    send_request(FUNC_NONZERO,   12'hAAA, 32'h0003_0000);
    send_request(FUNC_ROW_END,   12'h000, 32'h0000_0000);
    send_request(FUNC_ROW_BEGIN, 12'h000, 32'h7FFF_FFFF);
    send_request(FUNC_NONZERO,   12'h000, 32'h7FFF_FFFF);
    send_request(FUNC_ROW_END,   12'h000, 32'h0000_0000);
    send_request(FUNC_ROW_BEGIN, 12'hFFF, 32'h8000_0000);
    send_request(FUNC_NONZERO,   12'hFFF, 32'h7FFF_FFFF);
    send_request(FUNC_ROW_END,   12'h000, 32'h0000_0000);
    send_request(FUNC_ROW_BEGIN, 12'h000, 32'h0000_0000);
    send_request(FUNC_NONZERO,   12'hFFF, 32'h8000_0000);
    send_request(FUNC_NONZERO,   12'hFFF, 32'h8000_0000);
    send_request(FUNC_ROW_END,   12'h000, 32'h0000_0000);
    send_request(FUNC_ROW_BEGIN, 12'h000, 32'h0000_0000);
    send_request(FUNC_NONZERO,   12'hFFF, 32'h8000_0000);
    send_request(FUNC_ROW_BEGIN, 12'h000, 32'h0005_0000);
    send_request(FUNC_NONZERO,   12'h555, 32'h0002_0000);
    send_request(FUNC_NONZERO,   12'h555, 32'h0000_0001);
    send_request(FUNC_ROW_END,   12'h000, 32'h0000_0000);
    drain();

    // random rows under each idle and stall mix
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 84; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 9;  stall_pct = 9;  end
      endcase
      repeat (16) send_request(FUNC_LOAD_X, IndexW'($urandom), rand_value());
      phase_start = requests_sent;
      while (requests_sent - phase_start < PhaseItems) begin
        if ($urandom_range(0, 99) < 85) send_row();
        else send_noise();
      end
      drain();
    end

    $display("run covered %0d requests, %0d row sums checked, %0d of them clipped",
             requests_sent, rows_checked, rows_clipped);
    $display("directed extremes and rounding, then four idle/stall mixes with drains");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/csmv_pkg.sv
rtl/core/csmv_front.sv
rtl/core/csmv_fifo.sv
rtl/core/csmv_back.sv
rtl/core/csr_sparse_matvec_accumulate.sv
tb/sv/csmv_row_checker.sv
tb/sv/tb_csr_sparse_matvec_accumulate.sv
